FILE: rtl/prg_pkg.sv
// Shared types and constants for the primary ray generator.
package prg_pkg;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  localparam logic [1:0] ACT_SINGLE = 2'd0;
  localparam logic [1:0] ACT_JITTER = 2'd1;
  localparam logic [1:0] ACT_STRAT  = 2'd2;

  localparam logic [2:0] REG_FORWARD  = 3'd0;
  localparam logic [2:0] REG_UP       = 3'd1;
  localparam logic [2:0] REG_SIDE     = 3'd2;
  localparam logic [2:0] REG_DISTANCE = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_COLUMNS  = 3'd6;
  localparam logic [2:0] REG_ROWS     = 3'd7;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 60;

  // Unsigned restoring divider request and result.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  // Returns the signed Q1.18 component of a packed vector.
  function automatic logic signed [19:0] vec_comp(input logic [59:0] v, input logic [1:0] i);
    logic signed [19:0] c;
    case (i)
      2'd0:    c = v[19:0];
      2'd1:    c = v[39:20];
      2'd2:    c = v[59:40];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/prg_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
module prg_div
  import prg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

FILE: rtl/prg_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module prg_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] sum;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sum      = res_r + bit_r;
    if (start) begin
      v_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= sum) begin
        v_nxt   = v_r - sum;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

FILE: rtl/primary_ray_generator.sv
// Primary ray generator top level: sequencer, shared multiplier and units.
// Per ray, the two plane offsets go through a single 64-step divider, then the
// sums, the normalizing shifts, the squares and the square root run, and the
// three normalizing quotients go one after another through the same divider.
// A jittered or stratified ray first takes two draws. A request gives one, four
// or sample_count rays (sample_count capped at MAX_SAMPLES), and the block takes
// no new word until its last ray has been taken.
module primary_ray_generator
  import prg_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int JITTER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [11:0]           in_pixel_col,
  input  logic [11:0]           in_pixel_row,
  input  logic [6:0]            in_sample_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [19:0]    out_ray_x,
  output logic signed [19:0]    out_ray_y,
  output logic signed [19:0]    out_ray_z,
  output logic [5:0]            out_sample_index,
  output logic                  out_last
);

  localparam int J = JITTER_BITS;
  localparam logic [6:0] MAX_CNT = 7'(MAX_SAMPLES);
  localparam logic signed [39:0] HALF = 40'sd1 <<< (J - 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DRAW1 = 14'b00000000000010,
    S_DRAW2 = 14'b00000000000100,
    S_VDIV  = 14'b00000000001000,
    S_VWAIT = 14'b00000000010000,
    S_HDIV  = 14'b00000000100000,
    S_HWAIT = 14'b00000001000000,
    S_MAC   = 14'b00000010000000,
    S_NORM  = 14'b00000100000000,
    S_SQ    = 14'b00001000000000,
    S_SQRT  = 14'b00010000000000,
    S_QDIV  = 14'b00100000000000,
    S_QWAIT = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [59:0] fwd_r, up_r, side_r;
  logic [23:0] dist_r, width_r, height_r;
  logic [12:0] cols_r, rows_r;
  logic [31:0] lfsr_r, lfsr_nxt;

  logic [1:0]  act_r, act_nxt;
  logic [11:0] col_r, col_nxt, row_r, row_nxt;
  logic [6:0]  cnt_r, cnt_nxt, k_r, k_nxt;
  logic signed [39:0] xo_r, xo_nxt, yo_r, yo_nxt;
  logic signed [39:0] v_r, v_nxt, h_r, h_nxt;
  logic        neg_sgn_r, neg_sgn_nxt;
  logic [3:0]  step_r, step_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [63:0] mag_r [3];
  logic [63:0] mag_nxt [3];
  logic [2:0]  neg_r, neg_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [31:0] n_r, n_nxt;
  logic [19:0] ray_r [3];
  logic [19:0] ray_nxt [3];
  logic        last_r, last_nxt;
  logic [5:0]  idx_r, idx_nxt;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;

  logic [31:0] lfsr_step;
  logic [J-1:0] draw_val;
  logic signed [39:0] draw_s, draw_h;
  logic [12:0] res_sel;
  logic [23:0] size_sel;
  logic signed [39:0] coord;
  logic signed [39:0] diff;
  logic [39:0] dmag;
  logic signed [32:0] mul_a;
  logic signed [37:0] mul_b;
  logic signed [63:0] prod;
  logic [1:0]  ci;
  logic [63:0] mx;
  logic signed [63:0] qsign;
  logic        last_cur;

  prg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  prg_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_r),
                    .done(sq_done), .root(sq_root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r    <= '0;
      up_r     <= '0;
      side_r   <= '0;
      dist_r   <= 24'd65536;
      width_r  <= 24'd65536;
      height_r <= 24'd65536;
      cols_r   <= 13'd1;
      rows_r   <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        {1'b0, REG_FORWARD}:  fwd_r    <= cfg_data;
        {1'b0, REG_UP}:       up_r     <= cfg_data;
        {1'b0, REG_SIDE}:     side_r   <= cfg_data;
        {1'b0, REG_DISTANCE}: dist_r   <= cfg_data[23:0];
        {1'b0, REG_WIDTH}:    width_r  <= cfg_data[23:0];
        {1'b0, REG_HEIGHT}:   height_r <= cfg_data[23:0];
        {1'b0, REG_COLUMNS}:  cols_r   <= cfg_data[12:0];
        {1'b0, REG_ROWS}:     rows_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lfsr_step = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);
    draw_val  = lfsr_step[J-1:0];
    draw_s    = 40'(draw_val);
    draw_h    = 40'(draw_val >> 1);
  end

  always_comb begin
    state_nxt   = state_r;
    lfsr_nxt    = lfsr_r;
    act_nxt     = act_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    xo_nxt      = xo_r;
    yo_nxt      = yo_r;
    v_nxt       = v_r;
    h_nxt       = h_r;
    neg_sgn_nxt = neg_sgn_r;
    step_nxt    = step_r;
    acc_nxt     = acc_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    sum_nxt     = sum_r;
    n_nxt       = n_r;
    ray_nxt     = ray_r;
    last_nxt    = last_r;
    idx_nxt     = idx_r;
    dreq        = '0;
    sq_start    = 1'b0;
    in_ready    = 1'b0;

    res_sel  = (state_r == S_VDIV) ? rows_r : cols_r;
    if (res_sel == 13'd0) res_sel = 13'd1;
    size_sel = (state_r == S_VDIV) ? height_r : width_r;
    coord    = (state_r == S_VDIV) ? ((40'(row_r) <<< J) + yo_r)
                                   : ((40'(col_r) <<< J) + xo_r);
    diff     = (40'(res_sel) <<< J) - (coord <<< 1);
    dmag     = diff[39] ? 40'(-diff) : 40'(diff);

    ci = step_r[3:2];
    case (step_r[1:0])
      2'd0:    begin mul_a = 33'(vec_comp(fwd_r, ci));  mul_b = 38'(dist_r); end
      2'd1:    begin mul_a = 33'(vec_comp(up_r, ci));   mul_b = v_r[37:0];   end
      2'd2:    begin mul_a = 33'(vec_comp(side_r, ci)); mul_b = h_r[37:0];   end
      default: begin
        mul_a = {1'b0, mag_r[ci][31:0]};
        mul_b = {6'd0, mag_r[ci][31:0]};
      end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);

    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    qsign = neg_r[ci] ? -$signed(drsp.quot) : $signed(drsp.quot);
    last_cur = (act_r == ACT_SINGLE) || (act_r == ACT_STRAT && k_r == 7'd3) ||
               (act_r == ACT_JITTER && k_r == cnt_r - 7'd1);

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt = in_action;
          col_nxt = in_pixel_col;
          row_nxt = in_pixel_row;
          cnt_nxt = (in_sample_count > MAX_CNT) ? MAX_CNT : in_sample_count;
          k_nxt   = '0;
          xo_nxt  = '0;
          yo_nxt  = '0;
          case (in_action)
            ACT_SINGLE: state_nxt = S_VDIV;
            ACT_JITTER: state_nxt = (in_sample_count == 7'd0) ? S_IDLE : S_DRAW1;
            ACT_STRAT:  state_nxt = S_DRAW1;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DRAW1: begin
        lfsr_nxt = lfsr_step;
        if (act_r == ACT_JITTER) yo_nxt = draw_s - HALF;
        else xo_nxt = k_r[0] ? draw_h : draw_h - HALF;
        state_nxt = S_DRAW2;
      end
      S_DRAW2: begin
        lfsr_nxt = lfsr_step;
        if (act_r == ACT_JITTER) xo_nxt = draw_s - HALF;
        else yo_nxt = k_r[1] ? draw_h : draw_h - HALF;
        state_nxt = S_VDIV;
      end
      S_VDIV, S_HDIV: begin
        dreq.start  = 1'b1;
        dreq.num    = 64'(dmag) * 64'(size_sel);
        dreq.den    = 64'(res_sel) << (J + 1);
        neg_sgn_nxt = diff[39];
        state_nxt   = (state_r == S_VDIV) ? S_VWAIT : S_HWAIT;
      end
      S_VWAIT: begin
        if (drsp.done) begin
          v_nxt     = neg_sgn_r ? -$signed(drsp.quot[39:0]) : $signed(drsp.quot[39:0]);
          state_nxt = S_HDIV;
        end
      end
      S_HWAIT: begin
        if (drsp.done) begin
          h_nxt     = neg_sgn_r ? -$signed(drsp.quot[39:0]) : $signed(drsp.quot[39:0]);
          step_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (step_r[1:0] == 2'd2) begin
          acc_nxt      = '0;
          neg_nxt[ci]  = (acc_r + prod) < 0;
          mag_nxt[ci]  = ((acc_r + prod) < 0) ? 64'(-(acc_r + prod)) : 64'(acc_r + prod);
          step_nxt     = {step_r[3:2] + 2'd1, 2'd0};
          if (ci == 2'd2) state_nxt = S_NORM;
        end else begin
          acc_nxt  = acc_r + prod;
          step_nxt = step_r + 4'd1;
        end
      end
      S_NORM: begin
        if (mx == 64'd0) begin
          ray_nxt   = '{default: 20'd0};
          idx_nxt   = k_r[5:0];
          last_nxt  = last_cur;
          state_nxt = S_OUT;
        end else if (mx >= 64'h8000_0000) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else if (mx < 64'h4000_0000) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          sum_nxt   = '0;
          step_nxt  = 4'd3;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sum_nxt  = sum_r + prod;
        step_nxt = step_r + 4'd4;
        if (ci == 2'd2) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          n_nxt     = sq_root;
          step_nxt  = '0;
          state_nxt = S_QDIV;
        end else if (step_r != 4'd0) begin
          sq_start = 1'b1;
          step_nxt = '0;
        end
      end
      S_QDIV: begin
        dreq.start = 1'b1;
        dreq.num   = (mag_r[ci] << 18) + 64'(n_r >> 1);
        dreq.den   = 64'(n_r);
        state_nxt  = S_QWAIT;
      end
      S_QWAIT: begin
        if (drsp.done) begin
          ray_nxt[ci] = qsign[19:0];
          idx_nxt     = k_r[5:0];
          last_nxt    = last_cur;
          step_nxt    = {step_r[3:2] + 2'd1, 2'd0};
          state_nxt   = (ci == 2'd2) ? S_OUT : S_QDIV;
        end
      end
      S_OUT: begin
        if (out_valid && out_ready) begin
          k_nxt     = k_r + 7'd1;
          state_nxt = last_r ? S_IDLE : S_DRAW1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lfsr_r  <= LFSR_SEED;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lfsr_r  <= lfsr_nxt;
      ov_r    <= (state_nxt == S_OUT) && !(ov_r && out_ready);
    end
    act_r     <= act_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    xo_r      <= xo_nxt;
    yo_r      <= yo_nxt;
    v_r       <= v_nxt;
    h_r       <= h_nxt;
    neg_sgn_r <= neg_sgn_nxt;
    step_r    <= step_nxt;
    acc_r     <= acc_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    sum_r     <= sum_nxt;
    n_r       <= n_nxt;
    ray_r     <= ray_nxt;
    last_r    <= last_nxt;
    idx_r     <= idx_nxt;
  end

  assign out_valid        = ov_r;
  assign out_ray_x        = ray_r[0];
  assign out_ray_y        = ray_r[1];
  assign out_ray_z        = ray_r[2];
  assign out_sample_index = idx_r;
  assign out_last         = last_r;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the primary ray generator: directed table, then random requests.
module tb_top
  import prg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [19:0] x, y, z;
    logic [5:0] idx;
    logic lst;
  } ray_t;

  typedef struct {
    int phase;
    logic [1:0] act;
    logic [11:0] col, row;
    logic [6:0] cnt;
    bit has_exp;
    logic signed [19:0] x, y, z;
  } stim_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [11:0] in_pixel_col = '0, in_pixel_row = '0;
  logic [6:0] in_sample_count = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [19:0] out_ray_x, out_ray_y, out_ray_z;
  logic [5:0] out_sample_index;
  logic out_last;

  // Model copy of the camera setup and the jitter generator.
  logic [59:0] cam_fwd, cam_up, cam_side;
  logic [23:0] cam_dist, cam_wid, cam_hgt;
  logic [12:0] cam_cols, cam_rows;
  logic [31:0] jitter;

  ray_t ray_q[$];
  int mismatches = 0;
  int rays_seen = 0;
  bit calm_tx = 0, calm_rx = 0;

  always #1 clk = ~clk;

  primary_ray_generator DUT (.*);

  function automatic longint vec_part(logic [59:0] v, int i);
    logic signed [19:0] c;
    c = v[20*i +: 20];
    return c;
  endfunction

  function automatic longint plane_off(longint unsigned size, longint unsigned res, longint c);
    longint unsigned r, mag, q;
    longint diff;
    r = (res == 0) ? 1 : res;
    diff = longint'(r << 16) - 2 * c;
    mag = (diff < 0) ? -diff : diff;
    q = (mag * size) / (r << 17);
    return (diff < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint next_jitter();
    logic lsb;
    lsb = jitter[0];
    jitter = jitter >> 1;
    if (lsb) jitter = jitter ^ LFSR_TAPS;
    return longint'(jitter[15:0]);
  endfunction

  function automatic ray_t trace(longint col, longint row, longint xo, longint yo, int k, bit lst);
    ray_t r;
    longint v, h, s, d, q;
    longint unsigned m[3], mx, sum, n, rem, bitv;
    bit neg[3];
    d = cam_dist;
    v = plane_off(cam_hgt, cam_rows, (row << 16) + yo);
    h = plane_off(cam_wid, cam_cols, (col << 16) + xo);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      s = vec_part(cam_fwd, i) * d + vec_part(cam_up, i) * v + vec_part(cam_side, i) * h;
      neg[i] = s < 0;
      m[i] = neg[i] ? -s : s;
      if (m[i] > mx) mx = m[i];
    end
    r.idx = k[5:0];
    r.lst = lst;
    r.x = 0;
    r.y = 0;
    r.z = 0;
    if (mx == 0) return r;
    while (mx >= 64'h8000_0000) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < 64'h4000_0000) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    rem = sum;
    n = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= n + bitv) begin
        rem = rem - (n + bitv);
        n = (n >> 1) + bitv;
      end else begin
        n = n >> 1;
      end
      bitv = bitv >> 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 18) + (n >> 1)) / n;
      if (neg[i]) q = -q;
      case (i)
        0: r.x = q[19:0];
        1: r.y = q[19:0];
        default: r.z = q[19:0];
      endcase
    end
    return r;
  endfunction

  // Queues the rays expected for one accepted request word.
  function automatic void predict_rays(logic [1:0] act, logic [11:0] col, logic [11:0] row,
                                       logic [6:0] cnt);
    int n;
    longint xo, yo;
    if (act == ACT_SINGLE) begin
      ray_q.insert(ray_q.size(), trace(col, row, 0, 0, 0, 1));
    end else if (act == ACT_JITTER) begin
      n = (cnt > 64) ? 64 : cnt;
      for (int k = 0; k < n; k++) begin
        yo = next_jitter() - 32768;
        xo = next_jitter() - 32768;
        ray_q.insert(ray_q.size(), trace(col, row, xo, yo, k, k == n - 1));
      end
    end else if (act == ACT_STRAT) begin
      for (int k = 0; k < 4; k++) begin
        xo = (next_jitter() >> 1) - ((k & 1) ? 0 : 32768);
        yo = (next_jitter() >> 1) - ((k & 2) ? 0 : 32768);
        ray_q.insert(ray_q.size(), trace(col, row, xo, yo, k, k == 3));
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [59:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FORWARD:  cam_fwd = val;
      REG_UP:       cam_up = val;
      REG_SIDE:     cam_side = val;
      REG_DISTANCE: cam_dist = val[23:0];
      REG_WIDTH:    cam_wid = val[23:0];
      REG_HEIGHT:   cam_hgt = val[23:0];
      REG_COLUMNS:  cam_cols = val[12:0];
      REG_ROWS:     cam_rows = val[12:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    wait (ray_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(logic [1:0] act, logic [11:0] col, logic [11:0] row, logic [6:0] cnt,
                           output int first);
    if (!calm_tx && $urandom_range(0, 99) < 25) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_sample_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    first = ray_q.size();
    predict_rays(act, col, row, cnt);
  endtask

  task automatic setup_phase(int p);
    case (p)
      1: begin
        write_reg(REG_FORWARD, {20'h40000, 20'h0, 20'h0});
        write_reg(REG_UP, {20'h0, 20'h40000, 20'h0});
        write_reg(REG_SIDE, {20'h0, 20'h0, 20'h40000});
        write_reg(REG_DISTANCE, 24'h010000);
        write_reg(REG_WIDTH, 24'h010000);
        write_reg(REG_HEIGHT, 24'h010000);
        write_reg(REG_COLUMNS, 13'd4096);
        write_reg(REG_ROWS, 13'd4096);
      end
      2: begin
        write_reg(REG_FORWARD, {20'h80000, 20'hFFFFF, 20'h7FFFF});
        write_reg(REG_UP, {20'h7FFFF, 20'h80000, 20'h00001});
        write_reg(REG_SIDE, {20'hC0000, 20'h40000, 20'h80000});
        write_reg(REG_DISTANCE, 24'hFFFFFF);
        write_reg(REG_WIDTH, 24'h000000);
        write_reg(REG_HEIGHT, 24'hFFFFFF);
        write_reg(REG_COLUMNS, 13'd0);
        write_reg(REG_ROWS, 13'd1);
        write_reg(REG_UNUSED, {60{1'b1}});
      end
      default: begin
        write_reg(REG_FORWARD, {$urandom, $urandom});
        write_reg(REG_UP, {$urandom, $urandom});
        write_reg(REG_SIDE, {$urandom, $urandom});
        write_reg(REG_DISTANCE, $urandom_range(0, 99) < 20 ? 0 : $urandom);
        write_reg(REG_WIDTH, $urandom);
        write_reg(REG_HEIGHT, $urandom);
        write_reg(REG_COLUMNS, $urandom_range(0, 4096));
        write_reg(REG_ROWS, $urandom_range(1, 4096));
      end
    endcase
  endtask

  stim_t plan[] = '{
    '{0, ACT_SINGLE, 12'd0, 12'd0, 7'd1, 1, 20'sd0, 20'sd0, 20'sd0},
    '{0, ACT_JITTER, 12'd4095, 12'd4095, 7'd3, 1, 20'sd0, 20'sd0, 20'sd0},
    '{0, ACT_STRAT, 12'd100, 12'd200, 7'd0, 1, 20'sd0, 20'sd0, 20'sd0},
    '{0, ACT_NONE, 12'd5, 12'd5, 7'd5, 0, 20'sd0, 20'sd0, 20'sd0},
    '{0, ACT_JITTER, 12'd0, 12'd0, 7'd0, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_SINGLE, 12'd2048, 12'd2048, 7'd0, 1, 20'sd0, 20'sd0, 20'sd262144},
    '{1, ACT_SINGLE, 12'd0, 12'd0, 7'd0, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_SINGLE, 12'd4095, 12'd4095, 7'd127, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_JITTER, 12'd4095, 12'd0, 7'd100, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_JITTER, 12'd0, 12'd4095, 7'd64, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_STRAT, 12'd4095, 12'd4095, 7'd1, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_STRAT, 12'd0, 12'd0, 7'd127, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_NONE, 12'd4095, 12'd4095, 7'd127, 0, 20'sd0, 20'sd0, 20'sd0},
    '{1, ACT_JITTER, 12'd1365, 12'd2730, 7'd1, 0, 20'sd0, 20'sd0, 20'sd0},
    '{2, ACT_SINGLE, 12'd4095, 12'd0, 7'd0, 0, 20'sd0, 20'sd0, 20'sd0},
    '{2, ACT_JITTER, 12'd123, 12'd4000, 7'd2, 0, 20'sd0, 20'sd0, 20'sd0},
    '{2, ACT_STRAT, 12'd0, 12'd4095, 7'd0, 0, 20'sd0, 20'sd0, 20'sd0},
    '{2, ACT_SINGLE, 12'd0, 12'd0, 7'd0, 0, 20'sd0, 20'sd0, 20'sd0}
  };

  // Request driver: directed table, then random phases.
  initial begin
    int phase, first, cnt;
    logic [1:0] act;
    cam_fwd = '0;
    cam_up = '0;
    cam_side = '0;
    cam_dist = 24'h010000;
    cam_wid = 24'h010000;
    cam_hgt = 24'h010000;
    cam_cols = 13'd1;
    cam_rows = 13'd1;
    jitter = LFSR_SEED;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    phase = 0;
    foreach (plan[i]) begin
      if (plan[i].phase != phase) begin
        drain();
        phase = plan[i].phase;
        setup_phase(phase);
      end
      send_word(plan[i].act, plan[i].col, plan[i].row, plan[i].cnt, first);
      if (plan[i].has_exp)
        for (int j = first; j < ray_q.size(); j++) begin
          ray_q[j].x = plan[i].x;
          ray_q[j].y = plan[i].y;
          ray_q[j].z = plan[i].z;
        end
    end
    for (int p = 3; p < 8; p++) begin
      drain();
      setup_phase(p);
      calm_tx = (p == 5);
      for (int i = 0; i < 27; i++) begin
        act = $urandom_range(0, 99) < 5 ? ACT_NONE : $urandom_range(0, 2);
        cnt = $urandom_range(0, 99);
        cnt = cnt < 85 ? $urandom_range(1, 6) : cnt < 92 ? $urandom_range(0, 127) :
              $urandom_range(7, 20);
        send_word(act, $urandom_range(0, 4095), $urandom_range(0, 4095), cnt, first);
      end
    end
    calm_tx = 0;
    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Ray sink with random back-pressure and one long hold-off.
  initial begin
    bit held;
    held = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && rays_seen >= 60) begin
        held = 1;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      calm_rx = rays_seen >= 150 && rays_seen < 350;
      out_ready <= calm_rx ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    ray_t e;
    if (rst_n && out_valid && out_ready) begin
      rays_seen++;
      if (ray_q.size() == 0) begin
        $error("unexpected ray word");
        mismatches++;
      end else begin
        e = ray_q.pop_front();
        if (out_ray_x !== e.x) begin
          $error("ray_x expected %0d actual %0d", e.x, out_ray_x);
          mismatches++;
        end
        if (out_ray_y !== e.y) begin
          $error("ray_y expected %0d actual %0d", e.y, out_ray_y);
          mismatches++;
        end
        if (out_ray_z !== e.z) begin
          $error("ray_z expected %0d actual %0d", e.z, out_ray_z);
          mismatches++;
        end
        if (out_sample_index !== e.idx) begin
          $error("sample_index expected %0d actual %0d", e.idx, out_sample_index);
          mismatches++;
        end
        if (out_last !== e.lst) begin
          $error("last expected %0d actual %0d", e.lst, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
